// File: src/dmxrx_pkg.sv
// Shared types and constants for the DMX512 slot receiver.
// No dependencies; imported by every module of the block.
package dmxrx_pkg;

  localparam int unsigned MAX_SLOTS_DEF = 512;

  localparam int unsigned START_W  = 9;
  localparam int unsigned WINLEN_W = 10;
  localparam int unsigned TICKS_W  = 8;
  localparam int unsigned CFG_W    = 10;
  localparam int unsigned CFGIDX_W = 2;
  localparam int unsigned OFFS_W   = 9;

  // request codes
  localparam logic [1:0] REQ_BREAK = 2'd0;
  localparam logic [1:0] REQ_BYTE  = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  // register indexes
  localparam logic [CFGIDX_W-1:0] CFG_START_SLOT    = 2'd0;
  localparam logic [CFGIDX_W-1:0] CFG_WINDOW_LENGTH = 2'd1;
  localparam logic [CFGIDX_W-1:0] CFG_TIMEOUT_TICKS = 2'd2;

  localparam logic [START_W-1:0]  START_SLOT_RST    = 9'd0;
  localparam logic [WINLEN_W-1:0] WINDOW_LENGTH_RST = 10'd1;
  localparam logic [TICKS_W-1:0]  TIMEOUT_TICKS_RST = 8'd30;

  // start codes
  localparam logic [7:0] SC_DMX = 8'h00;
  localparam logic [7:0] SC_RDM = 8'hCC;

  typedef struct packed {
    logic [START_W-1:0]  start_slot;
    logic [WINLEN_W-1:0] window_length;
    logic [TICKS_W-1:0]  timeout_ticks;
  } dmxrx_cfg_t;

  typedef struct packed {
    logic [7:0]        slot_data;
    logic [OFFS_W-1:0] slot_offset;
    logic              in_window;
    logic              window_commit;
    logic              rdm_byte;
    logic              signal_present;
  } dmxrx_res_t;

endpackage

// File: src/dmxrx_cfg_regs.sv
// Configuration register file: start slot, window length and timeout.
// Depends on dmxrx_pkg.
module dmxrx_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dmxrx_pkg::CFGIDX_W-1:0]  cfg_idx_i,
  input  logic [dmxrx_pkg::CFG_W-1:0]     cfg_wdata_i,
  output dmxrx_pkg::dmxrx_cfg_t           cfg_o
);
  import dmxrx_pkg::*;

  dmxrx_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_slot    <= START_SLOT_RST;
      cfg_q.window_length <= WINDOW_LENGTH_RST;
      cfg_q.timeout_ticks <= TIMEOUT_TICKS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_START_SLOT:    cfg_q.start_slot    <= cfg_wdata_i[START_W-1:0];
        CFG_WINDOW_LENGTH: cfg_q.window_length <= cfg_wdata_i[WINLEN_W-1:0];
        CFG_TIMEOUT_TICKS: cfg_q.timeout_ticks <= cfg_wdata_i[TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: src/dmxrx_core.sv
// Receiver state (phase, slot counts, frame status, timeout) and the
// per-event next-state and result logic. Depends on dmxrx_pkg.
module dmxrx_core #(
  parameter int unsigned MaxSlots = dmxrx_pkg::MAX_SLOTS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [1:0]            req_type_i,
  input  logic [7:0]            rx_byte_i,
  input  dmxrx_pkg::dmxrx_cfg_t cfg_i,
  output dmxrx_pkg::dmxrx_res_t res_o
);
  import dmxrx_pkg::*;

  localparam int unsigned CntW = $clog2(MaxSlots + 1);
  localparam int unsigned WinW = WINLEN_W + 1;
  localparam int unsigned CmpW = (CntW > WinW) ? CntW : WinW;

  typedef enum logic [1:0] {
    PH_WAIT  = 2'd0,
    PH_START = 2'd1,
    PH_DMX   = 2'd2,
    PH_RDM   = 2'd3
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [CntW-1:0]     prev_q, prev_d;
  logic                good_q, good_d;
  logic [TICKS_W-1:0]  tmo_q, tmo_d;

  logic [WinW-1:0]     win_end;
  logic [CntW-1:0]     cnt_inc;
  logic [CmpW-1:0]     diff;
  dmxrx_res_t          res;

  assign win_end = WinW'(cfg_i.start_slot) + WinW'(cfg_i.window_length);
  assign cnt_inc = CntW'(cnt_q + 1'b1);
  assign diff    = CmpW'(cnt_q) - CmpW'(cfg_i.start_slot);

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    prev_d  = prev_q;
    good_d  = good_q;
    tmo_d   = tmo_q;
    res     = '0;
    case (req_type_i)
      REQ_BREAK: phase_d = PH_START;
      REQ_TICK: begin
        if (tmo_q != '0) begin
          tmo_d = tmo_q - 1'b1;
          if (tmo_q == TICKS_W'(1)) good_d = 1'b0;
        end
      end
      REQ_BYTE: begin
        case (phase_q)
          PH_START: begin
            if (rx_byte_i == SC_RDM) begin
              phase_d = PH_RDM;
            end else if (rx_byte_i == SC_DMX) begin
              phase_d = PH_DMX;
              if (cnt_q != prev_q || cnt_q == '0) begin
                good_d = 1'b0;
                prev_d = cnt_q;
              end else begin
                good_d = 1'b1;
                tmo_d  = cfg_i.timeout_ticks;
              end
              cnt_d = '0;
            end else begin
              phase_d = PH_WAIT;
            end
          end
          PH_DMX: begin
            if (cnt_q < CntW'(MaxSlots)) begin
              cnt_d = cnt_inc;
              if (CmpW'(cnt_q) >= CmpW'(cfg_i.start_slot) &&
                  CmpW'(cnt_q) < CmpW'(win_end)) begin
                res.in_window   = 1'b1;
                res.slot_data   = rx_byte_i;
                res.slot_offset = diff[OFFS_W-1:0];
              end
              if (good_q && CmpW'(cnt_inc) == CmpW'(win_end)) begin
                res.window_commit = 1'b1;
              end
            end else begin
              phase_d = PH_WAIT;
            end
          end
          PH_RDM:  res.rdm_byte = 1'b1;
          default: ;
        endcase
      end
      default: ;
    endcase
    res.signal_present = (tmo_d != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WAIT;
      cnt_q   <= '0;
      prev_q  <= '0;
      good_q  <= 1'b0;
      tmo_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      prev_q  <= prev_d;
      good_q  <= good_d;
      tmo_q   <= tmo_d;
    end
  end

  assign res_o = res;

endmodule

// File: src/dmx512_slot_receiver_top.sv
// Top level of the DMX512 slot receiver: input register, core, result register.
// Depends on dmxrx_pkg, dmxrx_cfg_regs and dmxrx_core.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one line event per beat:
//   a break, a received byte or a 100 ms tick. Output channel
//   (out_valid_o/out_ready_i) returns exactly one result per event, in order.
//   The event is registered in the input stage, then evaluated against
//   receiver state into the result register when the core advances.
//   One event per cycle is sustained while out_ready_i accepts each result;
//   the limit is back-pressure on the output channel.
//   Configuration writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) take effect at
//   the clock edge and are meant for idle periods only.
//   Reset clears both stages, the receiver state (waiting for break, no
//   signal) and loads the register defaults.
//   When the receiver stalls, the result register holds, the input stage
//   fills, and in_ready_o drops until the result is taken.
module dmx512_slot_receiver_top #(
  parameter int unsigned MaxSlots = dmxrx_pkg::MAX_SLOTS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [dmxrx_pkg::CFGIDX_W-1:0]   cfg_idx_i,
  input  logic [dmxrx_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [1:0]                       req_type_i,
  input  logic [7:0]                       rx_byte_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [7:0]                       slot_data_o,
  output logic [dmxrx_pkg::OFFS_W-1:0]     slot_offset_o,
  output logic                             in_window_o,
  output logic                             window_commit_o,
  output logic                             rdm_byte_o,
  output logic                             signal_present_o
);
  import dmxrx_pkg::*;

  dmxrx_cfg_t cfg;
  dmxrx_res_t res, res_q;

  logic       s1_valid_q;
  logic [1:0] s1_req_q;
  logic [7:0] s1_byte_q;
  logic       out_valid_q;
  logic       advance;

  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_req_q  <= req_type_i;
      s1_byte_q <= rx_byte_i;
    end
  end

  dmxrx_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  dmxrx_core #(
    .MaxSlots (MaxSlots)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .req_type_i (s1_req_q),
    .rx_byte_i  (s1_byte_q),
    .cfg_i      (cfg),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign slot_data_o      = res_q.slot_data;
  assign slot_offset_o    = res_q.slot_offset;
  assign in_window_o      = res_q.in_window;
  assign window_commit_o  = res_q.window_commit;
  assign rdm_byte_o       = res_q.rdm_byte;
  assign signal_present_o = res_q.signal_present;

endmodule

// File: tb/tb_dmx512_slot_receiver_top.sv
// Self-checking testbench for dmx512_slot_receiver_top: drives line events, predicts every
// result beat in a scoreboard class and compares it field by field on the output channel.
// Depends on dmxrx_pkg and the dmx512_slot_receiver_top RTL.
`timescale 1ns / 1ps

module tb_dmx512_slot_receiver_top;
  import dmxrx_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned RUN_LIMIT_NS = 2_000_000;

  typedef enum logic [1:0] {PH_WAIT, PH_START, PH_DMX, PH_RDM} rx_phase_e;

  class dmx_slot_scoreboard;
    logic [START_W-1:0]  cfg_start;
    logic [WINLEN_W-1:0] cfg_len;
    logic [TICKS_W-1:0]  cfg_ticks;
    rx_phase_e           phase;
    logic [9:0]          slot_cnt;
    logic [9:0]          prev_total;
    logic [1:0]          good;
    logic [7:0]          tmo;
    dmxrx_res_t          expected_slots[$];
    int                  errors;

    function new();
      cfg_start  = START_SLOT_RST;
      cfg_len    = WINDOW_LENGTH_RST;
      cfg_ticks  = TIMEOUT_TICKS_RST;
      phase      = PH_WAIT;
      slot_cnt   = '0;
      prev_total = '0;
      good       = '0;
      tmo        = '0;
      errors     = 0;
    endfunction

    function void set_reg(logic [CFGIDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_START_SLOT:    cfg_start = val[START_W-1:0];
        CFG_WINDOW_LENGTH: cfg_len   = val[WINLEN_W-1:0];
        CFG_TIMEOUT_TICKS: cfg_ticks = val[TICKS_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_slots.size();
    endfunction

    function void note_event(logic [1:0] req, logic [7:0] b);
      dmxrx_res_t  r;
      int unsigned idx;
      int unsigned win_end;
      r = '0;
      case (req)
        REQ_BREAK: phase = PH_START;
        REQ_TICK: begin
          if (tmo != 0) begin
            tmo = tmo - 1'b1;
            if (tmo == 0) good = '0;
          end
        end
        REQ_BYTE: begin
          case (phase)
            PH_START: begin
              if (b == SC_RDM) begin
                phase = PH_RDM;
              end else if (b == SC_DMX) begin
                phase = PH_DMX;
                if (slot_cnt != prev_total || slot_cnt == 0) begin
                  good = '0;
                  prev_total = slot_cnt;
                end else begin
                  good = 2'd1;
                  tmo = cfg_ticks;
                end
                slot_cnt = '0;
              end else begin
                phase = PH_WAIT;
              end
            end
            PH_DMX: begin
              if (slot_cnt < MAX_SLOTS_DEF) begin
                idx = slot_cnt;
                win_end = cfg_start + cfg_len;
                slot_cnt = slot_cnt + 1'b1;
                if (idx >= cfg_start && idx < win_end) begin
                  r.in_window   = 1'b1;
                  r.slot_data   = b;
                  r.slot_offset = OFFS_W'(idx - cfg_start);
                end
                if (good != 0 && slot_cnt == win_end) begin
                  good = 2'd2;
                  r.window_commit = 1'b1;
                end
              end else begin
                phase = PH_WAIT;
              end
            end
            PH_RDM: r.rdm_byte = 1'b1;
            default: ;
          endcase
        end
        default: ;
      endcase
      r.signal_present = (tmo != 0);
      expected_slots.push_back(r);
    endfunction

    function void compare_field(string name, logic [8:0] want, logic [8:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(dmxrx_res_t got);
      dmxrx_res_t want;
      if (expected_slots.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, got);
        errors++;
        return;
      end
      want = expected_slots.pop_front();
      compare_field("slot_data", want.slot_data, got.slot_data);
      compare_field("slot_offset", want.slot_offset, got.slot_offset);
      compare_field("in_window", want.in_window, got.in_window);
      compare_field("window_commit", want.window_commit, got.window_commit);
      compare_field("rdm_byte", want.rdm_byte, got.rdm_byte);
      compare_field("signal_present", want.signal_present, got.signal_present);
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CFGIDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]    cfg_wdata_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [1:0]          req_type_i;
  logic [7:0]          rx_byte_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [7:0]          slot_data_o;
  logic [OFFS_W-1:0]   slot_offset_o;
  logic                in_window_o;
  logic                window_commit_o;
  logic                rdm_byte_o;
  logic                signal_present_o;

  dmxrx_res_t          out_beat;
  dmx_slot_scoreboard  sb;
  int                  snd_idle_pct;
  int                  rcv_idle_pct;

  dmx512_slot_receiver_top uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .req_type_i       (req_type_i),
    .rx_byte_i        (rx_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .slot_data_o      (slot_data_o),
    .slot_offset_o    (slot_offset_o),
    .in_window_o      (in_window_o),
    .window_commit_o  (window_commit_o),
    .rdm_byte_o       (rdm_byte_o),
    .signal_present_o (signal_present_o)
  );

  assign out_beat = {slot_data_o, slot_offset_o, in_window_o, window_commit_o,
                     rdm_byte_o, signal_present_o};

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= rcv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_event(req_type_i, rx_byte_i);
      if (out_valid_o && out_ready_i) sb.check_result(out_beat);
    end
  end

  task automatic set_idling(input int snd_pct, input int rcv_pct);
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
  endtask

  task automatic write_reg(input logic [CFGIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    sb.set_reg(idx, val);
    @(negedge clk_i);
  endtask

  task automatic configure(input logic [START_W-1:0] start, input logic [WINLEN_W-1:0] wlen,
                           input logic [TICKS_W-1:0] ticks);
    write_reg(CFG_START_SLOT, start);
    write_reg(CFG_WINDOW_LENGTH, wlen);
    write_reg(CFG_TIMEOUT_TICKS, ticks);
    cfg_we_i <= 1'b0;
  endtask

  // valid stays up after a beat; the next call either re-drives or drops it
  task automatic send_event(input logic [1:0] req, input logic [7:0] b);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic send_dmx_frame(input int len);
    send_event(REQ_BREAK, 8'($urandom));
    send_event(REQ_BYTE, SC_DMX);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 3)
        send_event($urandom_range(1) ? REQ_TICK : REQ_UNUSED, 8'($urandom));
      send_event(REQ_BYTE, 8'($urandom));
    end
  endtask

  // mostly well-formed frames of repeating length so that frames turn good
  task automatic run_traffic(input int budget, input int len_lo, input int len_hi);
    int         sent;
    int         len;
    int         pick;
    int         n;
    logic [7:0] b;
    sent = 0;
    len = $urandom_range(len_hi, len_lo);
    while (sent < budget) begin
      pick = $urandom_range(99);
      if (pick < 78) begin
        if ($urandom_range(3) == 0) len = $urandom_range(len_hi, len_lo);
        send_dmx_frame(len);
        sent += len + 2;
      end else if (pick < 86) begin
        n = $urandom_range(4);
        send_event(REQ_BREAK, 8'($urandom));
        send_event(REQ_BYTE, SC_RDM);
        repeat (n) send_event(REQ_BYTE, 8'($urandom));
        sent += n + 2;
      end else if (pick < 91) begin
        do b = 8'($urandom); while (b == SC_DMX || b == SC_RDM);
        send_event(REQ_BREAK, 8'($urandom));
        send_event(REQ_BYTE, b);
        repeat ($urandom_range(3)) send_event(REQ_BYTE, 8'($urandom));
        sent += 2;
      end else if (pick < 95) begin
        send_event(REQ_BREAK, 8'($urandom));
        send_event(REQ_BYTE, SC_DMX);
        sent += 2;
      end else begin
        repeat ($urandom_range(4, 1)) send_event(2'($urandom_range(3)), 8'($urandom));
      end
      if ($urandom_range(99) < 30)
        repeat ($urandom_range(5, 1)) send_event(REQ_TICK, 8'($urandom));
    end
  endtask

  initial begin
    sb = new();
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    req_type_i  = REQ_BREAK;
    rx_byte_i   = '0;
    out_ready_i = 1'b0;
    set_idling(22, 86);
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    configure(9'd1, 10'd2, 8'd2);
    send_event(REQ_UNUSED, 8'hFF);
    send_event(REQ_BYTE, 8'h00);
    send_event(REQ_TICK, 8'h00);
    send_event(REQ_BREAK, 8'hFF);
    send_event(REQ_BYTE, SC_RDM);
    send_event(REQ_BYTE, 8'hFF);
    send_event(REQ_BYTE, 8'h00);
    send_event(REQ_BREAK, 8'h00);
    send_event(REQ_BYTE, 8'h5A);
    send_event(REQ_BYTE, 8'h12);
    repeat (3) send_dmx_frame(3);
    send_event(REQ_TICK, 8'hFF);
    send_event(REQ_TICK, 8'h00);
    settle();

    configure(9'd0, 10'd1, 8'd30);
    run_traffic(34, 1, 5);
    settle();
    configure(9'd3, 10'd4, 8'd1);
    run_traffic(34, 6, 9);
    settle();

    set_idling(86, 22);
    configure(9'd5, 10'd0, 8'd0);
    run_traffic(34, 4, 7);
    settle();
    configure(9'd511, 10'd512, 8'd255);
    run_traffic(34, 2, 8);
    settle();

    // full-size frame: every slot in the window, overflow on the 513th byte
    set_idling(0, 0);
    configure(9'd0, 10'd512, 8'd255);
    send_dmx_frame(513);
    settle();
    configure(9'd0, 10'd7, 8'd4);
    run_traffic(34, 5, 9);
    settle();
    repeat (8) @(negedge clk_i);

    if (sb.errors == 0 && sb.pending() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("status: fail");
    $finish;
  end

endmodule
